[src/ehr_pkg.sv]
package ehr_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COUNT_BITS = 16;
  localparam int RATE_BITS = 8;
  localparam int PITCH_BITS = 10;
  localparam int TICK_REG_BITS = 15;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 15;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SAMPLE_BITS:0] diff_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [RATE_BITS-1:0] rate_t;
  typedef logic [PITCH_BITS-1:0] pitch_t;
  typedef logic [TICK_REG_BITS-1:0] ticks_t;

  typedef logic [1:0] lead_t;
  localparam lead_t LEAD_ONE = 2'd0;
  localparam lead_t LEAD_TWO = 2'd1;
  localparam lead_t LEAD_THREE = 2'd2;
  localparam lead_t LEAD_NONE = 2'd3;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  localparam cfg_index_t REG_LEAD_SELECT = 2'd0;
  localparam cfg_index_t REG_TIMEOUT_TICKS = 2'd1;
  localparam cfg_index_t REG_REFRACTORY_TICKS = 2'd2;

  localparam lead_t LEAD_SELECT_RESET = LEAD_THREE;
  localparam ticks_t TIMEOUT_RESET = ticks_t'(5000);
  localparam ticks_t REFRACTORY_RESET = ticks_t'(100);

  localparam diff_t LEAD_ONE_LOW = diff_t'(-1600);
  localparam diff_t LEAD_ONE_HIGH = diff_t'(-800);
  localparam diff_t LEAD_TWO_LOW = diff_t'(800);
  localparam diff_t LEAD_TWO_HIGH = diff_t'(1600);
  localparam diff_t LEAD_THREE_LOW = diff_t'(1000);
  localparam diff_t LEAD_THREE_HIGH = diff_t'(2000);

  localparam count_t RATE_NUMERATOR = count_t'(60000);
  localparam rate_t RATE_MAX = '1;
  localparam pitch_t PITCH_BASE = pitch_t'(320);

  typedef struct packed {
    logic start;
    count_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    count_t quotient;
  } div_rsp_t;

  function automatic pitch_t tone_of(rate_t rate);
    return PITCH_BASE + {1'b0, rate, 1'b0};
  endfunction

endpackage

[src/ehr_if.sv]
interface ehr_sample_if;
  logic valid;
  logic ready;
  ehr_pkg::sample_t sample_lead_one;
  ehr_pkg::sample_t sample_lead_two;
  ehr_pkg::sample_t sample_lead_three;

  modport source (
    output valid, sample_lead_one, sample_lead_two, sample_lead_three,
    input ready
  );
  modport sink (
    input valid, sample_lead_one, sample_lead_two, sample_lead_three,
    output ready
  );
endinterface

interface ehr_result_if;
  logic valid;
  logic ready;
  ehr_pkg::rate_t heart_rate;
  logic beat_found;
  logic timed_out;
  ehr_pkg::pitch_t tone_pitch;

  modport source (
    output valid, heart_rate, beat_found, timed_out, tone_pitch,
    input ready
  );
  modport sink (
    input valid, heart_rate, beat_found, timed_out, tone_pitch,
    output ready
  );
endinterface

[src/ehr_divider.sv]
module ehr_divider (
  input  logic clk,
  input  logic rst,
  input  ehr_pkg::div_req_t req,
  output ehr_pkg::div_rsp_t rsp
);

  localparam int STEP_BITS = $clog2(ehr_pkg::COUNT_BITS);

  logic busy;
  logic [STEP_BITS-1:0] step;
  ehr_pkg::count_t divisor;
  ehr_pkg::count_t rem;
  ehr_pkg::count_t quot;
  logic done;

  logic [ehr_pkg::COUNT_BITS:0] shifted;
  logic [ehr_pkg::COUNT_BITS+1:0] trial;
  ehr_pkg::count_t rem_next;
  ehr_pkg::count_t quot_next;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem, quot[ehr_pkg::COUNT_BITS-1]};
    trial = {1'b0, shifted} - {2'b00, divisor};
    if (!trial[ehr_pkg::COUNT_BITS+1]) begin
      rem_next = trial[ehr_pkg::COUNT_BITS-1:0];
      quot_next = {quot[ehr_pkg::COUNT_BITS-2:0], 1'b1};
    end else begin
      rem_next = shifted[ehr_pkg::COUNT_BITS-1:0];
      quot_next = {quot[ehr_pkg::COUNT_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && !req.start && (step == '0);
      if (req.start) begin
        busy <= 1'b1;
        step <= STEP_BITS'(ehr_pkg::COUNT_BITS - 1);
        divisor <= req.divisor;
        rem <= '0;
        quot <= ehr_pkg::RATE_NUMERATOR;
      end else if (busy) begin
        rem <= rem_next;
        quot <= quot_next;
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quot;

endmodule

[src/ecg_heart_rate_detector.sv]
// ECG heart rate detector.
// sample_in takes one word per 1 ms tick with the filtered samples of leads
// I, II and III. result_out gives one word per tick: heart_rate, beat_found,
// timed_out and tone_pitch (320 + 2 * heart_rate).
// The config port (cfg_write, cfg_index, cfg_data) writes lead_select,
// timeout_ticks and refractory_ticks; write it only while no tick is open.
// A tick without a beat goes from CHECK straight to FINISH and hands its result to
// the output register; the block is ready again in that same cycle. A tick with a
// beat first runs 60000 / count through a 16-bit restoring divider in DIVIDE, one
// quotient bit a cycle, before its result goes out through FINISH.
// sample_in.ready is high only while the block waits for a tick.
// The result sits in an output register; the next tick is taken while it
// waits. If the receiver still stalls when the next result is ready, the
// block holds that result and stays not ready until the register frees up.
// Synchronous reset clears count, kept sample and rate to zero, loads the
// register defaults (lead III, timeout 5000, refractory 100) and drops
// result_out.valid.
module ecg_heart_rate_detector (
  input  logic clk,
  input  logic rst,
  ehr_sample_if.sink sample_in,
  ehr_result_if.source result_out,
  input  logic cfg_write,
  input  ehr_pkg::cfg_index_t cfg_index,
  input  logic [ehr_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  typedef enum logic [1:0] {
    IDLE,
    CHECK,
    DIVIDE,
    FINISH
  } state_t;

  state_t state;

  ehr_pkg::lead_t lead_select;
  ehr_pkg::ticks_t timeout_ticks;
  ehr_pkg::ticks_t refractory_ticks;

  ehr_pkg::count_t tick_count;
  ehr_pkg::sample_t previous_sample;
  ehr_pkg::rate_t rate_register;
  ehr_pkg::sample_t current;
  logic beat;
  logic tout;

  ehr_pkg::div_req_t div_req;
  ehr_pkg::div_rsp_t div_rsp;
  logic div_start;

  logic out_valid;
  ehr_pkg::rate_t out_rate;
  logic out_beat;
  logic out_tout;
  ehr_pkg::pitch_t out_pitch;

  ehr_pkg::sample_t selected;
  ehr_pkg::diff_t diff;
  logic hit;
  logic accept;
  logic out_free;
  logic out_load;
  logic over_timeout;
  logic past_refractory;

  ehr_divider u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_select <= ehr_pkg::LEAD_SELECT_RESET;
      timeout_ticks <= ehr_pkg::TIMEOUT_RESET;
      refractory_ticks <= ehr_pkg::REFRACTORY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ehr_pkg::REG_LEAD_SELECT: lead_select <= cfg_data[1:0];
        ehr_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        ehr_pkg::REG_REFRACTORY_TICKS: refractory_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (lead_select)
      ehr_pkg::LEAD_ONE: selected = sample_in.sample_lead_one;
      ehr_pkg::LEAD_TWO: selected = sample_in.sample_lead_two;
      default: selected = sample_in.sample_lead_three;
    endcase
  end

  always_comb begin
    diff = ehr_pkg::diff_t'(current) - ehr_pkg::diff_t'(previous_sample);
    unique case (lead_select)
      ehr_pkg::LEAD_ONE:
        hit = (diff > ehr_pkg::LEAD_ONE_LOW) && (diff < ehr_pkg::LEAD_ONE_HIGH);
      ehr_pkg::LEAD_TWO:
        hit = (diff > ehr_pkg::LEAD_TWO_LOW) && (diff < ehr_pkg::LEAD_TWO_HIGH);
      ehr_pkg::LEAD_THREE:
        hit = (diff > ehr_pkg::LEAD_THREE_LOW) && (diff < ehr_pkg::LEAD_THREE_HIGH);
      default: hit = 1'b0;
    endcase
  end

  assign accept = sample_in.valid && sample_in.ready;
  assign out_free = !out_valid || result_out.ready;
  assign out_load = (state == FINISH) && out_free;
  assign sample_in.ready = (state == IDLE);
  assign over_timeout = tick_count > {1'b0, timeout_ticks};
  assign past_refractory = (tick_count > {1'b0, refractory_ticks}) &&
                           (lead_select != ehr_pkg::LEAD_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      tick_count <= '0;
      previous_sample <= '0;
      rate_register <= '0;
      beat <= 1'b0;
      tout <= 1'b0;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      div_start <= (state == CHECK) && !over_timeout && past_refractory && hit;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && result_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            current <= selected;
            tick_count <= tick_count + 1'b1;
            beat <= 1'b0;
            tout <= 1'b0;
            state <= CHECK;
          end
        end
        CHECK: begin
          if (over_timeout) begin
            rate_register <= '0;
            tick_count <= '0;
            tout <= 1'b1;
            state <= FINISH;
          end else if (past_refractory) begin
            previous_sample <= current;
            if (hit) begin
              beat <= 1'b1;
              state <= DIVIDE;
            end else begin
              state <= FINISH;
            end
          end else begin
            state <= FINISH;
          end
        end
        DIVIDE: begin
          if (div_rsp.done) begin
            rate_register <= (div_rsp.quotient > ehr_pkg::count_t'(ehr_pkg::RATE_MAX)) ?
                             ehr_pkg::RATE_MAX : div_rsp.quotient[ehr_pkg::RATE_BITS-1:0];
            tick_count <= '0;
            state <= FINISH;
          end
        end
        FINISH: begin
          if (out_load) begin
            out_rate <= rate_register;
            out_beat <= beat;
            out_tout <= tout;
            out_pitch <= ehr_pkg::tone_of(rate_register);
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign div_req.start = div_start;
  assign div_req.divisor = tick_count;

  assign result_out.valid = out_valid;
  assign result_out.heart_rate = out_rate;
  assign result_out.beat_found = out_beat;
  assign result_out.timed_out = out_tout;
  assign result_out.tone_pitch = out_pitch;

endmodule

[src/ehr_checker.sv]
module ehr_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input ehr_pkg::rate_t heart_rate,
  input logic beat_found,
  input logic timed_out,
  input ehr_pkg::pitch_t tone_pitch
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(heart_rate) &&
      $stable(beat_found) && $stable(timed_out) && $stable(tone_pitch))
    else $error("result word changed under stall");

  a_pitch: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tone_pitch == ehr_pkg::tone_of(heart_rate))
    else $error("tone pitch does not follow rate");

  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(beat_found && timed_out))
    else $error("beat and timeout on one tick");

  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && timed_out |-> heart_rate == '0)
    else $error("rate not cleared on timeout");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ecg_heart_rate_detector ehr_checker u_ehr_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(result_out.valid),
  .out_ready(result_out.ready),
  .heart_rate(result_out.heart_rate),
  .beat_found(result_out.beat_found),
  .timed_out(result_out.timed_out),
  .tone_pitch(result_out.tone_pitch)
);

[verif/tb_ecg_heart_rate_detector.sv]
`timescale 1ns / 1ps

module tb_ecg_heart_rate_detector;

  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT = 32;
  localparam int SETTLE_CYCLES = 25;
  localparam ehr_pkg::cfg_index_t REG_SPARE = 2'd3;

  typedef struct packed {
    ehr_pkg::rate_t heart_rate;
    logic beat_found;
    logic timed_out;
    ehr_pkg::pitch_t tone_pitch;
  } tick_result_t;

  logic clk;
  logic rst;
  logic cfg_write;
  ehr_pkg::cfg_index_t cfg_index;
  logic [ehr_pkg::CFG_DATA_BITS-1:0] cfg_data;

  ehr_sample_if sample_in ();
  ehr_result_if result_out ();

  ecg_heart_rate_detector dut (
    .clk(clk),
    .rst(rst),
    .sample_in(sample_in),
    .result_out(result_out),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // detector state and registers as the block should hold them
  ehr_pkg::count_t det_count;
  ehr_pkg::sample_t det_kept;
  ehr_pkg::rate_t det_rate;
  ehr_pkg::lead_t cfg_lead;
  ehr_pkg::ticks_t cfg_timeout;
  ehr_pkg::ticks_t cfg_refractory;

  tick_result_t pending_results[$];
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  int stall_request = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int ticks_sent = 0;
  int beats_seen = 0;
  int timeouts_seen = 0;
  int settings_used = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void window_of(input ehr_pkg::lead_t lead, output int lo, output int hi);
    case (lead)
      ehr_pkg::LEAD_ONE: begin
        lo = -1600;
        hi = -800;
      end
      ehr_pkg::LEAD_TWO: begin
        lo = 800;
        hi = 1600;
      end
      default: begin
        lo = 1000;
        hi = 2000;
      end
    endcase
  endfunction

  function automatic tick_result_t advance_detector(input ehr_pkg::sample_t one,
                                                     input ehr_pkg::sample_t two,
                                                     input ehr_pkg::sample_t three);
    tick_result_t res;
    ehr_pkg::sample_t watched;
    int diff;
    int lo;
    int hi;
    int quotient;
    res = '0;
    det_count = det_count + 1'b1;
    if (det_count > ehr_pkg::count_t'(cfg_timeout)) begin
      det_rate = '0;
      det_count = '0;
      res.timed_out = 1'b1;
    end else if (det_count > ehr_pkg::count_t'(cfg_refractory) &&
                 cfg_lead != ehr_pkg::LEAD_NONE) begin
      case (cfg_lead)
        ehr_pkg::LEAD_ONE: watched = one;
        ehr_pkg::LEAD_TWO: watched = two;
        default: watched = three;
      endcase
      diff = int'(watched) - int'(det_kept);
      window_of(cfg_lead, lo, hi);
      if (diff > lo && diff < hi) begin
        quotient = 60000 / int'(det_count);
        det_rate = (quotient > 255) ? 8'hFF : ehr_pkg::rate_t'(quotient);
        det_count = '0;
        res.beat_found = 1'b1;
      end
      det_kept = watched;
    end
    res.heart_rate = det_rate;
    res.tone_pitch = ehr_pkg::pitch_t'(320 + 2 * int'(det_rate));
    return res;
  endfunction

  task automatic note_mismatch(input string what, input tick_result_t want,
                               input tick_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected rate %0d beat %0b timeout %0b pitch %0d,",
               $time, what, want.heart_rate, want.beat_found, want.timed_out,
               want.tone_pitch,
               "  got rate %0d beat %0b timeout %0b pitch %0d",
               got.heart_rate, got.beat_found, got.timed_out, got.tone_pitch);
  endtask

  task automatic send_tick(input ehr_pkg::sample_t one, input ehr_pkg::sample_t two,
                           input ehr_pkg::sample_t three);
    while (sender_idles && $urandom_range(99) < IDLE_PCT) begin
      sample_in.valid <= 1'b0;
      @(posedge clk);
    end
    sample_in.valid <= 1'b1;
    sample_in.sample_lead_one <= one;
    sample_in.sample_lead_two <= two;
    sample_in.sample_lead_three <= three;
    @(posedge clk);
    while (!sample_in.ready) @(posedge clk);
    pending_results.push_back(advance_detector(one, two, three));
    ticks_sent++;
  endtask

  task automatic send_delta(input int delta);
    ehr_pkg::sample_t s;
    s = det_kept + ehr_pkg::sample_t'(delta);
    send_tick(s, s, s);
  endtask

  task automatic send_noise();
    send_tick(ehr_pkg::sample_t'($urandom), ehr_pkg::sample_t'($urandom),
              ehr_pkg::sample_t'($urandom));
  endtask

  // watched lead mostly steps into, onto or off its window; other leads random
  task automatic send_shaped(input int hit_pct);
    ehr_pkg::sample_t leads [3];
    ehr_pkg::lead_t watched;
    int lo;
    int hi;
    int delta;
    int pick;
    foreach (leads[i]) leads[i] = ehr_pkg::sample_t'($urandom);
    watched = (cfg_lead == ehr_pkg::LEAD_NONE) ? ehr_pkg::LEAD_THREE : cfg_lead;
    window_of(watched, lo, hi);
    pick = $urandom_range(99);
    delta = 0;
    if (pick < hit_pct) begin
      delta = lo + 1 + int'($urandom_range(hi - lo - 2));
    end else if (pick < hit_pct + 15) begin
      case ($urandom_range(3))
        0: delta = lo;
        1: delta = lo + 1;
        2: delta = hi - 1;
        default: delta = hi;
      endcase
    end else if (pick < hit_pct + 25) begin
      delta = int'($urandom_range(6000)) - 3000;
    end
    if (pick < hit_pct + 40) leads[watched] = det_kept + ehr_pkg::sample_t'(delta);
    send_tick(leads[0], leads[1], leads[2]);
  endtask

  task automatic settle();
    sample_in.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input ehr_pkg::lead_t lead, input int timeout,
                           input int refractory);
    logic [12:0] junk;
    logic [ehr_pkg::CFG_DATA_BITS-1:0] spare;
    junk = $urandom;
    spare = $urandom;
    settle();
    cfg_write <= 1'b1;
    cfg_index <= ehr_pkg::REG_LEAD_SELECT;
    cfg_data <= {junk, lead};
    @(posedge clk);
    cfg_index <= ehr_pkg::REG_TIMEOUT_TICKS;
    cfg_data <= ehr_pkg::ticks_t'(timeout);
    @(posedge clk);
    cfg_index <= ehr_pkg::REG_REFRACTORY_TICKS;
    cfg_data <= ehr_pkg::ticks_t'(refractory);
    @(posedge clk);
    // unused index, must change nothing
    cfg_index <= REG_SPARE;
    cfg_data <= spare;
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_lead = lead;
    cfg_timeout = ehr_pkg::ticks_t'(timeout);
    cfg_refractory = ehr_pkg::ticks_t'(refractory);
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    repeat (200) send_shaped(45);
  endtask

  task automatic test_directed();
    // zero timeout: every tick times out
    configure(ehr_pkg::LEAD_THREE, 0, 0);
    repeat (2) send_delta(1500);
    // lead I edges, saturated rate, sample extremes, then timeout
    configure(ehr_pkg::LEAD_ONE, 4, 0);
    send_delta(-1000);
    send_delta(-800);
    send_delta(-1600);
    send_delta(-801);
    send_delta(-1599);
    send_tick(ehr_pkg::sample_t'(8388607), ehr_pkg::sample_t'(8388607),
              ehr_pkg::sample_t'(8388607));
    send_tick(ehr_pkg::sample_t'(-8388608), ehr_pkg::sample_t'(-8388608),
              ehr_pkg::sample_t'(-8388608));
    repeat (3) send_delta(0);
    // lead II with refractory
    configure(ehr_pkg::LEAD_TWO, 3, 1);
    send_delta(1200);
    send_delta(1200);
    send_delta(800);
    send_delta(800);
    send_delta(1600);
    send_delta(0);
    // beat window edges of lead III
    configure(ehr_pkg::LEAD_THREE, 2, 0);
    send_delta(1001);
    send_delta(2000);
    send_delta(1999);
    send_delta(1000);
    // no lead watched
    configure(ehr_pkg::LEAD_NONE, 2, 0);
    send_delta(1500);
    send_delta(-1000);
    send_delta(1500);
    // refractory not below timeout
    configure(ehr_pkg::LEAD_TWO, 2, 2);
    repeat (3) send_delta(1200);
  endtask

  task automatic test_random_settings();
    int total;
    int timeout;
    int refractory;
    int cap;
    int hit;
    int n;
    ehr_pkg::lead_t lead;
    total = 0;
    // rate right at the saturation edge
    configure(ehr_pkg::LEAD_ONE, 300, 234);
    repeat (260) send_shaped(45);
    while (total < 400) begin
      lead = ($urandom_range(7) == 0) ? ehr_pkg::LEAD_NONE :
             ehr_pkg::lead_t'($urandom_range(2));
      case ($urandom_range(3))
        0: timeout = $urandom_range(40, 1);
        1: timeout = $urandom_range(400, 40);
        2: timeout = $urandom_range(900, 250);
        default: timeout = 32767;
      endcase
      cap = (timeout / 2 < 300) ? timeout / 2 : 300;
      case ($urandom_range(3))
        0: refractory = 0;
        1: refractory = (timeout > 32700) ? 32767 : $urandom_range(timeout + 20, timeout);
        default: refractory = $urandom_range(cap);
      endcase
      case ($urandom_range(2))
        0: hit = 45;
        1: hit = 10;
        default: hit = 2;
      endcase
      configure(lead, timeout, refractory);
      n = $urandom_range(160, 60);
      repeat (n) send_shaped(hit);
      total += n;
    end
  endtask

  task automatic test_backpressure();
    configure(ehr_pkg::LEAD_TWO, 50, 3);
    stall_request = 300;
    repeat (40) send_shaped(45);
    // sender waits for every result before going on
    settle();
    repeat (40) send_shaped(45);
  endtask

  task automatic test_long_count();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    // beat after a long quiet count
    configure(ehr_pkg::LEAD_TWO, 300, 250);
    repeat (250) send_noise();
    send_delta(1200);
    // count runs past the timeout with no beat possible
    configure(ehr_pkg::LEAD_ONE, 150, 150);
    repeat (151) send_noise();
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
  endtask

  always @(posedge clk) begin : receive_results
    tick_result_t got;
    tick_result_t want;
    if (rst) begin
      result_out.ready <= 1'b0;
    end else begin
      if (result_out.valid && result_out.ready) begin
        got = {result_out.heart_rate, result_out.beat_found, result_out.timed_out,
               result_out.tone_pitch};
        beats_seen += got.beat_found;
        timeouts_seen += got.timed_out;
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected word", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.heart_rate !== want.heart_rate || got.beat_found !== want.beat_found ||
              got.timed_out !== want.timed_out || got.tone_pitch !== want.tone_pitch)
            note_mismatch("wrong word", want, got);
        end
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        result_out.ready <= 1'b0;
      end else if (stall_request > 0) begin
        hold_left = stall_request - 1;
        stall_request = 0;
        result_out.ready <= 1'b0;
      end else begin
        result_out.ready <= !(receiver_idles && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_in.valid && sample_in.ready) ||
        (result_out.valid && result_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no word moved for %0d cycles, %0d results outstanding", STALL_LIMIT,
               pending_results.size());
      $display("tb_ecg_heart_rate_detector: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= ehr_pkg::REG_LEAD_SELECT;
    cfg_data <= '0;
    sample_in.valid <= 1'b0;
    sample_in.sample_lead_one <= '0;
    sample_in.sample_lead_two <= '0;
    sample_in.sample_lead_three <= '0;
    det_count = '0;
    det_kept = '0;
    det_rate = '0;
    cfg_lead = ehr_pkg::LEAD_THREE;
    cfg_timeout = ehr_pkg::ticks_t'(5000);
    cfg_refractory = ehr_pkg::ticks_t'(100);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random_settings();
    test_backpressure();
    test_long_count();
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d ticks over %0d register settings: all lead selections, timeout 0 to 32767,",
             ticks_sent, settings_used);
    $display("window edges, rate saturation, long counts; %0d beats, %0d timeouts",
             beats_seen, timeouts_seen);
    $display("%0d bad words", mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_ecg_heart_rate_detector: clean");
    end else begin
      $display("tb_ecg_heart_rate_detector: errors");
    end
    $finish;
  end

endmodule
